// ----- hdl/u2c_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_pkg
// Shared types, constants and the code point to glyph table of the UTF-8 to
// CP437 converter.
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam int CAP_W   = 16;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0]       CHAR_QMARK = 8'h3F;
  localparam logic [CAP_W-1:0] CAP_RESET  = 16'd256;

  // one result as it leaves the block
  typedef struct packed {
    logic [7:0]       code;
    logic             eos;
    logic [CAP_W-1:0] count;
  } result_t;

  // all results caused by one input byte (zero to two)
  typedef struct packed {
    logic [1:0]         nres;
    result_t [1:0]      res;
  } entry_t;

  function automatic logic [7:0] glyph_of(input logic [15:0] cp);
    logic [7:0] g;
    case (cp)
      16'h00E1: g = 8'hA0;
      16'h00E9: g = 8'h82;
      16'h00ED: g = 8'hA1;
      16'h00F3: g = 8'hA2;
      16'h00FA: g = 8'hA3;
      16'h00F1: g = 8'hA4;
      16'h00D1: g = 8'hA5;
      16'h00FC: g = 8'h81;
      16'h00C9: g = 8'h90;
      16'h00BF: g = 8'hA8;
      16'h00A1: g = 8'hAD;
      16'h00B7: g = 8'hFA;
      16'h2665: g = 8'h03;
      16'h2591: g = 8'hB0;
      16'h221A: g = 8'hFB;
      16'h00C1: g = 8'h41;
      16'h00CD: g = 8'h49;
      16'h00D3: g = 8'h4F;
      16'h00DA: g = 8'h55;
      16'h00DC: g = 8'h55;
      default:  g = CHAR_QMARK;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/u2c_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_front
// Accept one byte per cycle while the queue has room, decode UTF-8 and keep
// the character count, and push the results of each byte as one queue entry.
// ----------------------------------------------------------------------------
module u2c_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [7:0]               data_byte,
  input  wire                      cfg_write,
  input  wire  [u2c_pkg::CAP_W-1:0] cfg_capacity,
  input  wire                      q_full,
  output logic                     push,
  output u2c_pkg::entry_t          push_entry
);
  import u2c_pkg::*;

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_SKIP   = 3'd1;
  localparam logic [2:0] MODE_TWO    = 3'd2;
  localparam logic [2:0] MODE_THREE1 = 3'd3;
  localparam logic [2:0] MODE_THREE2 = 3'd4;

  logic [2:0]       mode, mode_next;
  logic [15:0]      partial, partial_next;
  logic [CAP_W-1:0] count, count_next;
  logic [CAP_W-1:0] limit;

  logic             accept;
  logic             cont, full0, full_a, pre_req, pre_em, do_fresh;
  logic [CAP_W-1:0] cnt1, cnt2, count_a, count_b;
  logic             slot;
  entry_t           ent;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    cont         = (data_byte[7:6] == 2'b10);
    cnt1         = count + 1'b1;
    cnt2         = count + 2'd2;
    full0        = (count >= limit);
    mode_next    = mode;
    partial_next = partial;
    count_next   = count;
    ent          = '0;
    pre_req      = 1'b0;
    do_fresh     = 1'b0;

    case (mode)
      MODE_SKIP: begin
        if (!cont) begin
          mode_next = MODE_IDLE;
          do_fresh  = 1'b1;
        end
      end
      MODE_TWO, MODE_THREE2: begin
        mode_next = MODE_IDLE;
        if (cont) begin
          if (!full0) begin
            ent.res[0].code  = glyph_of(partial | {10'd0, data_byte[5:0]});
            ent.res[0].count = cnt1;
            ent.nres         = 2'd1;
            count_next       = cnt1;
          end
        end else begin
          pre_req  = 1'b1;
          do_fresh = 1'b1;
        end
      end
      MODE_THREE1: begin
        if (cont) begin
          partial_next = partial | {4'd0, data_byte[5:0], 6'd0};
          mode_next    = MODE_THREE2;
        end else begin
          mode_next = MODE_IDLE;
          pre_req   = 1'b1;
          do_fresh  = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        do_fresh  = 1'b1;
      end
    endcase

    // broken sequence: one '?' before the byte is taken afresh
    pre_em = pre_req && !full0;
    if (pre_em) begin
      ent.res[0].code  = CHAR_QMARK;
      ent.res[0].count = cnt1;
      ent.nres         = 2'd1;
      count_next       = cnt1;
    end
    count_a = pre_em ? cnt1 : count;
    count_b = pre_em ? cnt2 : cnt1;
    full_a  = pre_em ? (cnt1 >= limit) : full0;
    slot    = pre_em;

    if (do_fresh) begin
      if (data_byte == 8'd0) begin
        ent.res[slot].code  = 8'd0;
        ent.res[slot].eos   = 1'b1;
        ent.res[slot].count = count_a;
        ent.nres            = ent.nres + 2'd1;
        mode_next           = MODE_IDLE;
        partial_next        = '0;
        count_next          = '0;
      end else if (!full_a) begin
        if (!data_byte[7]) begin
          ent.res[slot].code  = data_byte;
          ent.res[slot].count = count_b;
          ent.nres            = ent.nres + 2'd1;
          count_next          = count_b;
        end else if (data_byte[7:5] == 3'b110) begin
          partial_next = {5'd0, data_byte[4:0], 6'd0};
          mode_next    = MODE_TWO;
        end else if (data_byte[7:4] == 4'b1110) begin
          partial_next = {data_byte[3:0], 12'd0};
          mode_next    = MODE_THREE1;
        end else begin
          ent.res[slot].code  = CHAR_QMARK;
          ent.res[slot].count = count_b;
          ent.nres            = ent.nres + 2'd1;
          count_next          = count_b;
          mode_next           = MODE_SKIP;
        end
      end
    end
  end

  assign push       = accept && (ent.nres != 2'd0);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      partial <= '0;
      count   <= '0;
      limit   <= CAP_RESET - 1'b1;
    end else begin
      if (accept) begin
        mode    <= mode_next;
        partial <= partial_next;
        count   <= count_next;
      end
      if (cfg_write) begin
        limit <= (cfg_capacity == '0) ? '0 : cfg_capacity - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && data_byte == 8'd0) |=> (count == '0 && mode == MODE_IDLE))
    else $error("count or mode not cleared after terminator");
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    (accept && count_next != '0) |-> (count_next <= limit || count_next == count))
    else $error("character count passed the limit");
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_TWO || mode == MODE_THREE1 || mode == MODE_THREE2) |-> (partial != 16'hFFFF))
    else $error("partial code point corrupt");
`endif

endmodule
`default_nettype wire

// ----- hdl/u2c_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_queue
// Short FIFO of per-byte result entries between the decode front and the
// output back.
// ----------------------------------------------------------------------------
module u2c_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire u2c_pkg::entry_t push_entry,
  input  wire                  pop,
  output u2c_pkg::entry_t      head,
  output logic                 q_valid,
  output logic                 q_full
);
  import u2c_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign q_valid = (fill != '0);
  assign q_full  = (fill == QCNT_W'(QDEPTH));
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !q_valid))
    else $error("pop from empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(QDEPTH))
    else $error("queue fill count out of range");
`endif

endmodule
`default_nettype wire

// ----- hdl/u2c_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_back
// Unpack queue entries into single results and hold them in the output
// register until taken.
// ----------------------------------------------------------------------------
module u2c_back (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       q_valid,
  input  wire u2c_pkg::entry_t      head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [7:0]                char_code,
  output logic                      end_of_string,
  output logic [u2c_pkg::CAP_W-1:0] char_count
);
  import u2c_pkg::*;

  logic    sel;
  logic    load;
  result_t cur;

  assign load = !out_valid || !out_stall;
  assign cur  = head.res[sel];
  assign pop  = q_valid && load && (sel || head.nres == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        sel <= !pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      char_code     <= cur.code;
      end_of_string <= cur.eos;
      char_count    <= cur.count;
    end
  end

`ifndef SYNTHESIS
  a_sel_has_entry: assert property (@(posedge clk) disable iff (rst)
    sel |-> q_valid)
    else $error("second result selected with empty queue");
  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (head.nres == 2'd1 || head.nres == 2'd2))
    else $error("queue entry with no results");
  a_sel_two: assert property (@(posedge clk) disable iff (rst)
    sel |-> head.nres == 2'd2)
    else $error("second result selected on single-result entry");
`endif

endmodule
`default_nettype wire

// ----- hdl/utf8_to_cp437_converter_top.sv -----
`default_nettype none
// Path: a byte accepted by the front is written into the result queue, and
//   the back then loads its first result into the output register.
// Throughput: one byte per cycle while the queue is not full; the output
//   port delivers one result per cycle when not stalled, so a byte with two
//   results takes longer to drain, absorbed by the four-entry result queue.
// Reset: synchronous; clears decode state, count and queue, capacity 256.
// ----------------------------------------------------------------------------
// utf8_to_cp437_converter_top
// UTF-8 byte stream to CP437 characters with a bounded character count and
// an end result per string.
// ----------------------------------------------------------------------------
module utf8_to_cp437_converter_top (
  input  wire                       clk,
  input  wire                       rst,
  // byte input
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  [7:0]                data_byte,
  // capacity register write
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [u2c_pkg::CAP_W-1:0] output_capacity,
  // result output
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [7:0]                char_code,
  output logic                      end_of_string,
  output logic [u2c_pkg::CAP_W-1:0] char_count
);
  import u2c_pkg::*;

  logic   push, pop, q_valid, q_full;
  entry_t push_entry, head;

  // the capacity register takes a request in any cycle
  assign cfg_ready = 1'b1;

  // front: decode each byte, advance the count, queue its results
  u2c_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_capacity (output_capacity),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  // hold results of bytes not yet delivered
  u2c_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_valid    (q_valid),
    .q_full     (q_full)
  );

  // back: drive one result per output request
  u2c_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .char_code     (char_code),
    .end_of_string (end_of_string),
    .char_count    (char_count)
  );

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to CP437 converter. A short directed
// string covers ASCII extremes, mapped and unmapped code points, broken and
// skipped sequences and the terminator. Phases of random strings follow, each
// under a new character capacity. A small scoreboard class tracks the decoder
// state, predicts every character and end result, and matches them in order.
// ----------------------------------------------------------------------------
module tb_top;
  import u2c_pkg::*;

  // decoder position inside a multi-byte sequence
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SKIP,
    SEQ_TWO,
    SEQ_THREE_A,
    SEQ_THREE_B
  } seq_state_e;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_PRINTS    = 100;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_BYTES   = 19;
  localparam int unsigned HOLD_CYCLES   = 150;

  // Scoreboard: shadow copy of the decoder plus the queue of characters
  // still owed by the block.
  class utf8_glyph_tracker;
    logic [CAP_W-1:0] capacity;
    seq_state_e       state;
    logic [15:0]      partial_cp;
    logic [CAP_W-1:0] emitted;
    result_t          pending_glyphs[$];
    bit [7:0]         glyph_by_cp[bit [15:0]];
    bit [15:0]        mapped_cps[$];
    int unsigned      mismatch_count;

    function new();
      capacity       = CAP_RESET;
      state          = SEQ_IDLE;
      partial_cp     = '0;
      emitted        = '0;
      mismatch_count = 0;
      add_glyph(16'h00E1, 8'hA0);
      add_glyph(16'h00E9, 8'h82);
      add_glyph(16'h00ED, 8'hA1);
      add_glyph(16'h00F3, 8'hA2);
      add_glyph(16'h00FA, 8'hA3);
      add_glyph(16'h00F1, 8'hA4);
      add_glyph(16'h00D1, 8'hA5);
      add_glyph(16'h00FC, 8'h81);
      add_glyph(16'h00C9, 8'h90);
      add_glyph(16'h00BF, 8'hA8);
      add_glyph(16'h00A1, 8'hAD);
      add_glyph(16'h00B7, 8'hFA);
      add_glyph(16'h2665, 8'h03);
      add_glyph(16'h2591, 8'hB0);
      add_glyph(16'h221A, 8'hFB);
      add_glyph(16'h00C1, "A");
      add_glyph(16'h00CD, "I");
      add_glyph(16'h00D3, "O");
      add_glyph(16'h00DA, "U");
      add_glyph(16'h00DC, "U");
    endfunction

    function void add_glyph(bit [15:0] cp, bit [7:0] g);
      glyph_by_cp[cp] = g;
      mapped_cps.push_back(cp);
    endfunction

    function logic [7:0] glyph(logic [15:0] cp);
      return glyph_by_cp.exists(cp) ? glyph_by_cp[cp] : CHAR_QMARK;
    endfunction

    // capacity counts the terminator; zero behaves as one
    function int unsigned room_limit();
      return (capacity == 0) ? 0 : capacity - 1;
    endfunction

    function void put_char(logic [7:0] ch);
      result_t r;
      if (emitted >= room_limit())
        return;
      emitted++;
      r.code  = ch;
      r.eos   = 1'b0;
      r.count = emitted;
      pending_glyphs.push_back(r);
    endfunction

    // a byte seen with no sequence open
    function void decode_lead(logic [7:0] b);
      result_t r;
      if (b == 8'h00) begin
        r.code  = 8'h00;
        r.eos   = 1'b1;
        r.count = emitted;
        pending_glyphs.push_back(r);
        state      = SEQ_IDLE;
        partial_cp = '0;
        emitted    = '0;
        return;
      end
      if (emitted >= room_limit())
        return;
      if (!b[7]) begin
        put_char(b);
      end else if (b[7:5] == 3'b110) begin
        partial_cp = {5'b0, b[4:0], 6'b0};
        state      = SEQ_TWO;
      end else if (b[7:4] == 4'b1110) begin
        partial_cp = {b[3:0], 12'b0};
        state      = SEQ_THREE_A;
      end else begin
        put_char(CHAR_QMARK);
        state = SEQ_SKIP;
      end
    endfunction

    // note one accepted byte and queue what it must produce
    function void take_byte(logic [7:0] b);
      bit tail;
      tail = (b[7:6] == 2'b10);
      case (state)
        SEQ_SKIP: begin
          if (!tail) begin
            state = SEQ_IDLE;
            decode_lead(b);
          end
        end
        SEQ_TWO, SEQ_THREE_B: begin
          state = SEQ_IDLE;
          if (tail) begin
            put_char(glyph(partial_cp | {10'b0, b[5:0]}));
          end else begin
            put_char(CHAR_QMARK);
            decode_lead(b);
          end
        end
        SEQ_THREE_A: begin
          if (tail) begin
            partial_cp = partial_cp | {4'b0, b[5:0], 6'b0};
            state      = SEQ_THREE_B;
          end else begin
            state = SEQ_IDLE;
            put_char(CHAR_QMARK);
            decode_lead(b);
          end
        end
        default: begin
          state = SEQ_IDLE;
          decode_lead(b);
        end
      endcase
    endfunction

    function int unsigned pending();
      return pending_glyphs.size();
    endfunction

    task flag_mismatch(string msg);
      if (mismatch_count < MAX_PRINTS)
        $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    // match one accepted result against the oldest owed one
    task match_char(logic [7:0] code, logic eos, logic [CAP_W-1:0] count);
      result_t want;
      if (pending_glyphs.size() == 0) begin
        flag_mismatch($sformatf("result %02h/%0b/%0d arrived with nothing owed",
                                code, eos, count));
        return;
      end
      want = pending_glyphs.pop_front();
      if (code !== want.code)
        flag_mismatch($sformatf("char_code %02h, expected %02h", code, want.code));
      if (eos !== want.eos)
        flag_mismatch($sformatf("end_of_string %0b, expected %0b", eos, want.eos));
      if (count !== want.count)
        flag_mismatch($sformatf("char_count %0d, expected %0d", count, want.count));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       data_byte;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] output_capacity;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       char_code;
  logic             end_of_string;
  logic [CAP_W-1:0] char_count;

  utf8_glyph_tracker tracker;

  // idle shaping, set per phase by the stimulus process
  int unsigned in_idle_max;
  int unsigned out_idle_max;
  int unsigned hold_off_len;
  int unsigned bytes_sent;
  int unsigned quiet_cycles = 0;

  always #10 clk = ~clk;

  utf8_to_cp437_converter_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .output_capacity (output_capacity),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .char_code       (char_code),
    .end_of_string   (end_of_string),
    .char_count      (char_count)
  );

  // Offer one byte after a random gap; hold it until the block takes it.
  // Valid is left high so a zero gap on the next byte keeps it asserted.
  task push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, in_idle_max);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_byte <= b;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  // Encode a code point as two or three bytes; short code points sent wide
  // give overlong forms, which the block decodes by value.
  task push_code_point(input logic [15:0] cp, input bit wide);
    if (wide) begin
      push_byte({4'b1110, cp[15:12]});
      push_byte({2'b10, cp[11:6]});
    end else begin
      push_byte({3'b110, cp[10:6]});
    end
    push_byte({2'b10, cp[5:0]});
  endtask

  // One random piece of a string: mostly well-formed text, some noise.
  task push_random_token();
    int unsigned pick;
    int unsigned n;
    logic [31:0] r;
    pick = $urandom_range(0, 99);
    r    = $urandom;
    if (pick < 35) begin
      // plain ASCII
      r = $urandom_range(1, 127);
      push_byte(r[7:0]);
    end else if (pick < 55) begin
      // a code point with a glyph in the table
      r = tracker.mapped_cps[$urandom_range(0, tracker.mapped_cps.size() - 1)];
      push_code_point(r[15:0], r[15:0] >= 16'h0800);
    end else if (pick < 70) begin
      // any code point, most of them unmapped
      n = $urandom_range(0, 1);
      r = (n != 0) ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, 16'h07FF);
      push_code_point(r[15:0], n != 0);
    end else if (pick < 80) begin
      push_byte(8'h00);
    end else if (pick < 88) begin
      // lead without all of its continuations: the next token usually breaks it
      if (r[31]) begin
        push_byte({3'b110, r[4:0]});
      end else begin
        push_byte({4'b1110, r[3:0]});
        if (r[30])
          push_byte({2'b10, r[13:8]});
      end
    end else if (pick < 94) begin
      // stray continuation run
      n = $urandom_range(1, 3);
      repeat (n) begin
        r = $urandom;
        push_byte({2'b10, r[5:0]});
      end
    end else begin
      // four-byte or invalid lead followed by continuations to skip
      push_byte({4'b1111, r[3:0]});
      n = $urandom_range(0, 3);
      repeat (n) begin
        r = $urandom;
        push_byte({2'b10, r[5:0]});
      end
    end
  endtask

  // Stop offering bytes, let every owed result drain, then give the block
  // a few cycles in case a sequence byte is still moving through it.
  task wait_all_glyphs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register once the block has gone quiet.
  task load_capacity(input logic [CAP_W-1:0] v);
    wait_all_glyphs();
    @(negedge clk);
    cfg_valid       <= 1'b1;
    output_capacity <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    tracker.capacity = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: stall for a random count before each result, or for a
  // long stretch when the stimulus asks for one, then take the next result.
  initial begin : result_sink
    int unsigned wait_cycles;
    out_stall = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off_len != 0) begin
        wait_cycles  = hold_off_len;
        hold_off_len = 0;
      end else begin
        wait_cycles = $urandom_range(0, out_idle_max);
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      tracker.match_char(char_code, end_of_string, char_count);
    end
  end

  // Watchdog: end the run if no request moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0]       opening[$];
    int unsigned      phase;
    logic [CAP_W-1:0] cap;
    tracker         = new();
    rst             = 1'b1;
    in_valid        = 1'b0;
    data_byte       = 8'h00;
    cfg_valid       = 1'b0;
    output_capacity = '0;
    in_idle_max     = 11;
    out_idle_max    = 11;
    hold_off_len    = 0;
    bytes_sent      = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed string at reset capacity: top ASCII, a mapped two-byte and a
    // mapped three-byte glyph, an overlong zero, a lead broken by ASCII, a
    // three-byte lead broken by the terminator (two results from one byte),
    // then a stray continuation, an 0xFF lead with a skipped tail, and a
    // three-byte lead broken right after its lead.
    opening = '{8'h7F, 8'hC3, 8'hB1, 8'hE2, 8'h99, 8'hA5, 8'hC0, 8'h80,
                8'hC3, 8'h41, 8'hE2, 8'h99, 8'h00,
                8'h80, 8'hBF, 8'hFF, 8'h98, 8'h44, 8'hE2, 8'h42, 8'h00};
    foreach (opening[i])
      push_byte(opening[i]);

    // Random phases. Each one ends wherever it lands, often mid-string, so
    // a lower capacity can take effect on a string already under way.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       cap = CAP_RESET;
        1:       cap = 16'd1;
        2:       cap = 16'd0;
        3:       cap = 16'hFFFF;
        4:       cap = 16'd4;
        5:       cap = 16'd2;
        6:       cap = 16'hFFFF;
        7:       cap = 16'd7;
        8:       cap = 16'd3;
        default: cap = 16'd5;
      endcase
      load_capacity(cap);
      // alternate busy and idle patterns on both sides
      in_idle_max  = phase[0] ? 11 : 0;
      out_idle_max = phase[1] ? 0 : 11;
      if (phase == 3) begin
        // hold results back while bytes keep coming, to fill the block
        in_idle_max  = 0;
        hold_off_len = HOLD_CYCLES;
      end
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES)
        push_random_token();
    end

    // close the last string and drain
    push_byte(8'h00);
    wait_all_glyphs();

    if (tracker.mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/u2c_pkg.sv
hdl/u2c_front.sv
hdl/u2c_queue.sv
hdl/u2c_back.sv
hdl/utf8_to_cp437_converter_top.sv
tb/tb_top.sv
